// ----- rtl/pats_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Proximity alarm tone sequencer package
// Shared types, register indexes and the tone lookup.
// ----------------------------------------------------------------------------
package pats_pkg;

  localparam int unsigned DistW    = 13;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned TickW    = 12;
  localparam int unsigned ToneW    = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TickW-1:0] ElapsedMax = {TickW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_ALERT_DISTANCE = 3'd0,
    REG_ALERT_HOLD     = 3'd1,
    REG_SCAN_TOGGLE    = 3'd2,
    REG_SCAN_ON        = 3'd3,
    REG_SCAN_OFF       = 3'd4,
    REG_ALERT_ON       = 3'd5,
    REG_ALERT_OFF      = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    TONE_NONE  = 2'd0,
    TONE_LOW   = 2'd1,
    TONE_HIGH  = 2'd2,
    TONE_ALERT = 2'd3
  } tone_code_t;

  typedef struct packed {
    logic [DistW-1:0] alert_distance_mm;
    logic [HoldW-1:0] alert_hold_ticks;
    logic [TickW-1:0] scan_toggle_ticks;
    logic [TickW-1:0] scan_on_ticks;
    logic [TickW-1:0] scan_off_ticks;
    logic [TickW-1:0] alert_on_ticks;
    logic [TickW-1:0] alert_off_ticks;
  } cfg_t;

  typedef struct packed {
    logic             buzzer_active;
    logic [ToneW-1:0] tone_hz;
    logic             alert_mode;
  } result_t;

  function automatic logic [ToneW-1:0] tone_hz_of(input tone_code_t code);
    logic [ToneW-1:0] hz;
    case (code)
      TONE_NONE:  hz = 12'd0;
      TONE_LOW:   hz = 12'd880;
      TONE_HIGH:  hz = 12'd1320;
      TONE_ALERT: hz = 12'd2400;
      default:    hz = 12'd0;
    endcase
    return hz;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pats_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Seven timing and threshold registers written through the configuration channel.
// ----------------------------------------------------------------------------
module pats_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [pats_pkg::CfgIdxW-1:0]   wr_index,
  input  wire logic [pats_pkg::CfgDataW-1:0]  wr_data,
  output pats_pkg::cfg_t                      cfg
);
  import pats_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alert_distance_mm <= 13'd200;
      cfg.alert_hold_ticks  <= 16'd600;
      cfg.scan_toggle_ticks <= 12'd35;
      cfg.scan_on_ticks     <= 12'd10;
      cfg.scan_off_ticks    <= 12'd25;
      cfg.alert_on_ticks    <= 12'd50;
      cfg.alert_off_ticks   <= 12'd40;
    end else if (wr_en) begin
      case (wr_index)
        REG_ALERT_DISTANCE: cfg.alert_distance_mm <= wr_data[DistW-1:0];
        REG_ALERT_HOLD:     cfg.alert_hold_ticks  <= wr_data[HoldW-1:0];
        REG_SCAN_TOGGLE:    cfg.scan_toggle_ticks <= wr_data[TickW-1:0];
        REG_SCAN_ON:        cfg.scan_on_ticks     <= wr_data[TickW-1:0];
        REG_SCAN_OFF:       cfg.scan_off_ticks    <= wr_data[TickW-1:0];
        REG_ALERT_ON:       cfg.alert_on_ticks    <= wr_data[TickW-1:0];
        REG_ALERT_OFF:      cfg.alert_off_ticks   <= wr_data[TickW-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pats_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer core
// Hold, scan toggle and duty cycle state, advanced once per accepted tick.
// ----------------------------------------------------------------------------
module pats_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic                        measure_valid,
  input  wire logic [pats_pkg::DistW-1:0]  distance_mm,
  input  pats_pkg::cfg_t                   cfg,
  output pats_pkg::result_t                result
);
  import pats_pkg::*;

  logic             mode_alert;
  logic [HoldW-1:0] hold_left;
  logic [TickW-1:0] toggle_elapsed;
  logic             tone_high;
  tone_code_t       current_tone;
  logic [TickW-1:0] duty_elapsed;
  logic             sounding;
  tone_code_t       latched_tone;

  logic             mode_alert_next;
  logic [HoldW-1:0] hold_left_next;
  logic [TickW-1:0] toggle_elapsed_next;
  logic             tone_high_next;
  tone_code_t       current_tone_next;
  logic [TickW-1:0] duty_elapsed_next;
  logic             sounding_next;
  tone_code_t       latched_tone_next;

  logic [HoldW-1:0] hold_dec;
  logic [TickW-1:0] toggle_adv;
  logic [TickW-1:0] duty_adv;
  logic [TickW-1:0] on_ticks;
  logic [TickW-1:0] off_ticks;

  always_comb begin
    hold_dec   = (hold_left != '0) ? hold_left - 1'b1 : hold_left;
    toggle_adv = (toggle_elapsed < ElapsedMax) ? toggle_elapsed + 1'b1 : ElapsedMax;
    duty_adv   = (duty_elapsed < ElapsedMax) ? duty_elapsed + 1'b1 : ElapsedMax;

    toggle_elapsed_next = toggle_adv;
    tone_high_next      = tone_high;
    current_tone_next   = current_tone;
    if (mode_alert) begin
      current_tone_next = TONE_ALERT;
      on_ticks          = cfg.alert_on_ticks;
      off_ticks         = cfg.alert_off_ticks;
    end else begin
      if (toggle_adv >= cfg.scan_toggle_ticks) begin
        toggle_elapsed_next = '0;
        tone_high_next      = !tone_high;
        current_tone_next   = tone_high ? TONE_LOW : TONE_HIGH;
      end
      on_ticks  = cfg.scan_on_ticks;
      off_ticks = cfg.scan_off_ticks;
    end

    duty_elapsed_next = duty_adv;
    sounding_next     = sounding;
    latched_tone_next = latched_tone;
    if (sounding) begin
      if (duty_adv >= on_ticks) begin
        sounding_next     = 1'b0;
        duty_elapsed_next = '0;
      end
    end else if (duty_adv >= off_ticks) begin
      sounding_next     = 1'b1;
      latched_tone_next = current_tone_next;
      duty_elapsed_next = '0;
    end

    hold_left_next  = hold_dec;
    mode_alert_next = mode_alert;
    if (measure_valid) begin
      if (distance_mm <= cfg.alert_distance_mm) begin
        hold_left_next = cfg.alert_hold_ticks;
      end
      mode_alert_next = (hold_left_next != '0);
    end

    result.buzzer_active = sounding_next;
    result.tone_hz       = tone_hz_of(latched_tone_next);
    result.alert_mode    = mode_alert_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_alert     <= 1'b0;
      hold_left      <= '0;
      toggle_elapsed <= '0;
      tone_high      <= 1'b0;
      current_tone   <= TONE_NONE;
      duty_elapsed   <= '0;
      sounding       <= 1'b0;
      latched_tone   <= TONE_NONE;
    end else if (accept) begin
      mode_alert     <= mode_alert_next;
      hold_left      <= hold_left_next;
      toggle_elapsed <= toggle_elapsed_next;
      tone_high      <= tone_high_next;
      current_tone   <= current_tone_next;
      duty_elapsed   <= duty_elapsed_next;
      sounding       <= sounding_next;
      latched_tone   <= latched_tone_next;
    end
  end

  // Tone is captured only on the off-to-on edge of the buzzer
  a_latch_on_turn_on: assert property (@(posedge clk) disable iff (rst)
    accept && !sounding && sounding_next |=> latched_tone == current_tone)
    else $error("latched tone differs from pending tone at turn-on");

  a_mode_needs_measure: assert property (@(posedge clk) disable iff (rst)
    accept && !measure_valid |=> $stable(mode_alert))
    else $error("mode changed on a tick without a measurement");

  a_mode_follows_hold: assert property (@(posedge clk) disable iff (rst)
    accept && measure_valid |=> mode_alert == (hold_left != '0))
    else $error("mode disagrees with hold after a measurement");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(duty_elapsed) && $stable(sounding) && $stable(hold_left))
    else $error("state advanced without an accepted tick");

endmodule
`default_nettype wire

// ----- rtl/proximity_alarm_tone_sequencer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Proximity alarm tone sequencer
// One request per millisecond tick; one result per request.
// ----------------------------------------------------------------------------
// Result: registered, valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the output is not stalled, set by the
//   single result register that parts the input and output sides.
// Reset: synchronous; core state returns to scan mode, buzzer off, 0 Hz tone,
//   configuration registers to their defaults; the result register is not reset.
module proximity_alarm_tone_sequencer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            measure_valid,
  input  wire logic [pats_pkg::DistW-1:0]      distance_mm,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 buzzer_active,
  output logic [pats_pkg::ToneW-1:0]           tone_hz,
  output logic                                 alert_mode,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pats_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [pats_pkg::CfgDataW-1:0]   cfg_data
);
  import pats_pkg::*;

  cfg_t    cfg;
  result_t result_new;
  result_t result;
  logic    accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  pats_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pats_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .measure_valid (measure_valid),
    .distance_mm   (distance_mm),
    .cfg           (cfg),
    .result        (result_new)
  );

  // Result register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_new;
    end
  end

  assign buzzer_active = result.buzzer_active;
  assign tone_hz       = result.tone_hz;
  assign alert_mode    = result.alert_mode;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Proximity alarm tone sequencer testbench
// Sends millisecond ticks, some with distance readings, through the unit.
// A cycle-free model of the hold, scan tone and buzzer duty logic predicts
// each result, and every result is compared field by field as it arrives.
// Settings change between phases, once all results are in. Both channels
// pause and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import pats_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  typedef struct {
    logic             measure;
    logic [DistW-1:0] distance;
  } tick_t;

  logic                clk;
  logic                rst           = 1'b1;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic                measure_valid = 1'b0;
  logic [DistW-1:0]    distance_mm   = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic                buzzer_active;
  logic [ToneW-1:0]    tone_hz;
  logic                alert_mode;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index     = '0;
  logic [CfgDataW-1:0] cfg_data      = '0;

  proximity_alarm_tone_sequencer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .measure_valid (measure_valid),
    .distance_mm   (distance_mm),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .buzzer_active (buzzer_active),
    .tone_hz       (tone_hz),
    .alert_mode    (alert_mode),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predicted sequencer state and settings
  cfg_t             p_cfg;
  logic             p_alert;
  logic [HoldW-1:0] p_hold;
  logic [TickW-1:0] p_toggle_cnt;
  logic             p_high_next;
  tone_code_t       p_pending;
  logic [TickW-1:0] p_duty_cnt;
  logic             p_buzz;
  tone_code_t       p_latched;

  tick_t       tick_backlog[$];
  result_t     alarm_due[$];
  int unsigned ticks_queued  = 0;
  int unsigned ticks_checked = 0;
  int unsigned faults        = 0;

  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  logic        calm_send  = 1'b0;
  logic        calm_recv  = 1'b0;

  function automatic void log_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endfunction

  // Advance the model by one tick and queue the result it produces
  function automatic void sequence_tick(input logic measure,
                                        input logic [DistW-1:0] distance);
    logic [TickW-1:0] on_t;
    logic [TickW-1:0] off_t;
    result_t          r;
    if (p_hold != '0) p_hold = p_hold - 1'b1;
    p_toggle_cnt = (p_toggle_cnt == ElapsedMax) ? p_toggle_cnt : p_toggle_cnt + 1'b1;
    p_duty_cnt   = (p_duty_cnt == ElapsedMax) ? p_duty_cnt : p_duty_cnt + 1'b1;
    if (p_alert) begin
      p_pending = TONE_ALERT;
      on_t      = p_cfg.alert_on_ticks;
      off_t     = p_cfg.alert_off_ticks;
    end else begin
      if (p_toggle_cnt >= p_cfg.scan_toggle_ticks) begin
        p_toggle_cnt = '0;
        p_high_next  = !p_high_next;
        p_pending    = p_high_next ? TONE_HIGH : TONE_LOW;
      end
      on_t  = p_cfg.scan_on_ticks;
      off_t = p_cfg.scan_off_ticks;
    end
    if (p_buzz) begin
      if (p_duty_cnt >= on_t) begin
        p_buzz     = 1'b0;
        p_duty_cnt = '0;
      end
    end else if (p_duty_cnt >= off_t) begin
      p_buzz     = 1'b1;
      p_latched  = p_pending;
      p_duty_cnt = '0;
    end
    // The mode only moves on ticks that carry a reading
    if (measure) begin
      if (distance <= p_cfg.alert_distance_mm) p_hold = p_cfg.alert_hold_ticks;
      p_alert = (p_hold != '0);
    end
    r.buzzer_active = p_buzz;
    case (p_latched)
      TONE_LOW:   r.tone_hz = 12'd880;
      TONE_HIGH:  r.tone_hz = 12'd1320;
      TONE_ALERT: r.tone_hz = 12'd2400;
      default:    r.tone_hz = 12'd0;
    endcase
    r.alert_mode = p_alert;
    alarm_due.push_back(r);
  endfunction

  // Request driver
  always @(posedge clk) begin
    tick_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) sequence_tick(measure_valid, distance_mm);
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (tick_backlog.size() != 0) begin
        nxt = tick_backlog.pop_front();
        in_valid      <= 1'b1;
        measure_valid <= nxt.measure;
        distance_mm   <= nxt.distance;
        if ($urandom_range(0, 39) == 0) calm_send = !calm_send;
        gap_left <= calm_send ? 0 : $urandom_range(0, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    result_t     want;
    int unsigned wait_n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      wait_n = stall_left;
      if (out_valid && !out_stall) begin
        if (alarm_due.size() == 0) begin
          log_fault($sformatf("unexpected result: buzzer %0b tone %0d mode %0b",
                              buzzer_active, tone_hz, alert_mode));
        end else begin
          want = alarm_due.pop_front();
          ticks_checked++;
          if (want.buzzer_active !== buzzer_active || want.tone_hz !== tone_hz ||
              want.alert_mode !== alert_mode)
            log_fault($sformatf(
              "result %0d: expected buzzer %0b tone %0d mode %0b, got buzzer %0b tone %0d mode %0b",
              ticks_checked, want.buzzer_active, want.tone_hz, want.alert_mode,
              buzzer_active, tone_hz, alert_mode));
        end
        if ($urandom_range(0, 39) == 0) calm_recv = !calm_recv;
        wait_n = calm_recv ? 0 : $urandom_range(0, 17);
      end
      if (wait_n != 0) begin
        out_stall  <= 1'b1;
        stall_left <= wait_n - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ALERT_DISTANCE: p_cfg.alert_distance_mm = val[DistW-1:0];
      REG_ALERT_HOLD:     p_cfg.alert_hold_ticks  = val[HoldW-1:0];
      REG_SCAN_TOGGLE:    p_cfg.scan_toggle_ticks = val[TickW-1:0];
      REG_SCAN_ON:        p_cfg.scan_on_ticks     = val[TickW-1:0];
      REG_SCAN_OFF:       p_cfg.scan_off_ticks    = val[TickW-1:0];
      REG_ALERT_ON:       p_cfg.alert_on_ticks    = val[TickW-1:0];
      REG_ALERT_OFF:      p_cfg.alert_off_ticks   = val[TickW-1:0];
      default: ;
    endcase
  endtask

  task automatic push_tick(input logic measure, input logic [DistW-1:0] distance);
    tick_t t;
    t.measure  = measure;
    t.distance = distance;
    tick_backlog.push_back(t);
    ticks_queued++;
  endtask

  // Distances cluster around the current threshold so both sides of it are hit
  task automatic queue_random_ticks(input int n, input int meas_pct);
    int               thr;
    int               k;
    logic [DistW-1:0] d;
    thr = p_cfg.alert_distance_mm;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: d = DistW'($urandom);
        1: begin
          k = thr + $urandom_range(0, 4) - 2;
          d = (k < 0) ? '0 : ((k > 8191) ? 13'd8191 : DistW'(k));
        end
        2: d = DistW'($urandom_range(0, thr));
        default: d = (thr >= 8191) ? 13'd8191 : DistW'($urandom_range(thr + 1, 8191));
      endcase
      push_tick($urandom_range(0, 99) < meas_pct, d);
    end
  endtask

  // Hold off until every request has its result back
  task automatic wait_idle();
    while (ticks_checked != ticks_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Upper data bits are junk on purpose: the unit must drop them
  task automatic draw_settings();
    write_reg(REG_ALERT_DISTANCE,
              CfgDataW'(($urandom & 16'hE000) | $urandom_range(0, 1200)));
    write_reg(REG_ALERT_HOLD, CfgDataW'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 3)
                                                                   : $urandom_range(4, 90)));
    write_reg(REG_SCAN_TOGGLE, CfgDataW'(($urandom & 16'hF000) | $urandom_range(0, 40)));
    write_reg(REG_SCAN_ON,     CfgDataW'(($urandom & 16'hF000) | $urandom_range(0, 25)));
    write_reg(REG_SCAN_OFF,    CfgDataW'(($urandom & 16'hF000) | $urandom_range(0, 25)));
    write_reg(REG_ALERT_ON,    CfgDataW'(($urandom & 16'hF000) | $urandom_range(0, 25)));
    write_reg(REG_ALERT_OFF,   CfgDataW'(($urandom & 16'hF000) | $urandom_range(0, 25)));
    if ($urandom_range(0, 2) == 0) write_reg(RegSpare, CfgDataW'($urandom));
  endtask

  initial begin
    p_cfg = '{alert_distance_mm: 13'd200, alert_hold_ticks: 16'd600,
              scan_toggle_ticks: 12'd35, scan_on_ticks: 12'd10, scan_off_ticks: 12'd25,
              alert_on_ticks: 12'd50, alert_off_ticks: 12'd40};
    p_alert      = 1'b0;
    p_hold       = '0;
    p_toggle_cnt = '0;
    p_high_next  = 1'b0;
    p_pending    = TONE_NONE;
    p_duty_cnt   = '0;
    p_buzz       = 1'b0;
    p_latched    = TONE_NONE;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Default settings: the buzzer turns on before any scan tone is chosen,
    // readings just above the threshold and readings that are ignored
    for (int i = 0; i < 24; i++) begin
      case (i % 6)
        0: push_tick(1'b1, 13'd8191);
        1: push_tick(1'b1, 13'd201);
        2: push_tick(1'b0, 13'd0);
        3: push_tick(1'b0, 13'd8191);
        default: push_tick(1'b0, DistW'($urandom));
      endcase
    end
    push_tick(1'b1, 13'd200);
    wait_idle();

    // Zero and one intervals fire every tick; a zero hold never enters alert
    write_reg(REG_ALERT_DISTANCE, 16'hFFFF);
    write_reg(REG_ALERT_HOLD,     16'h0000);
    write_reg(REG_SCAN_TOGGLE,    16'h0000);
    write_reg(REG_SCAN_ON,        16'h0001);
    write_reg(REG_SCAN_OFF,       16'h0000);
    write_reg(REG_ALERT_ON,       16'h0001);
    write_reg(REG_ALERT_OFF,      16'h0000);
    write_reg(RegSpare,           16'hFFFF);
    queue_random_ticks(40, 50);
    wait_idle();

    // A hold of one: alert is kept until the next reading clears it
    write_reg(REG_ALERT_DISTANCE, 16'd300);
    write_reg(REG_ALERT_HOLD,     16'd1);
    write_reg(REG_SCAN_TOGGLE,    16'd3);
    write_reg(REG_SCAN_OFF,       16'd2);
    queue_random_ticks(40, 30);
    wait_idle();

    // Long alert stretch with the widest intervals; the scan toggle count keeps running
    write_reg(REG_ALERT_DISTANCE, 16'd200);
    write_reg(REG_ALERT_HOLD,     16'hFFFF);
    write_reg(REG_SCAN_TOGGLE,    16'hFFFF);
    write_reg(REG_SCAN_ON,        16'h0FFF);
    write_reg(REG_SCAN_OFF,       16'h0FFF);
    write_reg(REG_ALERT_ON,       16'h0FFF);
    write_reg(REG_ALERT_OFF,      16'hFFFF);
    push_tick(1'b1, 13'd0);
    queue_random_ticks(100, 2);
    wait_idle();

    // Drop back to scan with a zero hold; the long toggle count must fire at once
    write_reg(REG_ALERT_HOLD,  16'h0000);
    write_reg(REG_SCAN_TOGGLE, 16'd40);
    write_reg(REG_SCAN_ON,     16'd2);
    write_reg(REG_SCAN_OFF,    16'd1);
    push_tick(1'b1, 13'd0);
    queue_random_ticks(50, 20);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      draw_settings();
      queue_random_ticks(70, $urandom_range(5, 60));
      wait_idle();
    end

    faults += alarm_due.size();
    if (faults == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- proximity_alarm_tone_sequencer_unit.f -----
rtl/pats_pkg.sv
rtl/pats_cfg.sv
rtl/pats_core.sv
rtl/proximity_alarm_tone_sequencer_unit.sv
tb/tb_top.sv
